// ===== src/sobel_pkg.sv =====
package sobel_pkg;

   typedef logic [7:0] pixel_type;

   // One line buffer entry: the pixel two rows up and the pixel one row up.
   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_pair_type;

   typedef logic [7:0] csr_index_type;
   typedef logic [11:0] csr_data_type;

   localparam csr_index_type REG_IMAGE_WIDTH  = 8'd0;
   localparam csr_index_type REG_IMAGE_HEIGHT = 8'd1;

   localparam int unsigned EDGE_MAX = 255;

   // |Gx| + |Gy| of the 3x3 Sobel kernels, saturated to 255.
   // Left column t0/m0/b0, center column t1/b1, right column t2/m2/b2.
   function automatic pixel_type sobel_magnitude(
      input pixel_type t0, input pixel_type t1, input pixel_type t2,
      input pixel_type m0, input pixel_type m2,
      input pixel_type b0, input pixel_type b1, input pixel_type b2
   );
      logic [9:0]  right_sum;
      logic [9:0]  left_sum;
      logic [9:0]  top_sum;
      logic [9:0]  bottom_sum;
      logic [9:0]  gx_abs;
      logic [9:0]  gy_abs;
      logic [10:0] total;
      right_sum  = 10'(t2) + {1'b0, m2, 1'b0} + 10'(b2);
      left_sum   = 10'(t0) + {1'b0, m0, 1'b0} + 10'(b0);
      top_sum    = 10'(t0) + {1'b0, t1, 1'b0} + 10'(t2);
      bottom_sum = 10'(b0) + {1'b0, b1, 1'b0} + 10'(b2);
      gx_abs = (right_sum >= left_sum) ? right_sum - left_sum : left_sum - right_sum;
      gy_abs = (top_sum >= bottom_sum) ? top_sum - bottom_sum : bottom_sum - top_sum;
      total  = 11'(gx_abs) + 11'(gy_abs);
      if (total > 11'(EDGE_MAX)) begin
         return 8'(EDGE_MAX);
      end
      return total[7:0];
   endfunction

endpackage

// ===== src/sobel_edge_magnitude.sv =====
// Streaming 3x3 Sobel edge detector for 8-bit grayscale frames.
// Pixels arrive in raster order on the req_ channel, one per transaction.
// For every pixel that completes a window centered on an interior pixel,
// one transaction leaves on the rsp_ channel with min(|Gx|+|Gy|, 255), the
// center row and column, and tlast set on the last interior pixel of the frame.
// Border pixels produce no output transaction.
// The csr_ channel writes the frame width (index 0) and height (index 1);
// values below 3 act as 3 and values above the maximum act as the maximum.
// A write also restarts the frame at row 0, column 0. Writes to unknown
// indexes are ignored and leave the frame position alone.
// Throughput is one pixel per clock while the receiver does not stall.
// The line buffer is read as a pixel is accepted into the read stage, and the
// Sobel arithmetic is loaded into the output register as the pixel leaves it.
// When the receiver stalls, the output register holds its transaction and one
// more pixel can be taken into the read stage before req_tready drops.
// Reset (synchronous, active high) restores width 640 and height 480, clears
// the window and the frame position. The line buffers need no clearing pass,
// since every result uses only entries written earlier in the same frame.
module sobel_edge_magnitude #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                    clock,
   input  logic                    reset,
   // Input pixels.
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // [7:0] pixel
   // Edge results.
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [31:0]             rsp_tdata,   // [7:0] edge_value, [18:8] center_row,
                                                // [29:19] center_col, [31:30] zero
   output logic                    rsp_tlast,   // frame_end
   // Configuration writes.
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  sobel_pkg::csr_index_type csr_index,
   input  sobel_pkg::csr_data_type  csr_data
);
   import sobel_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   localparam int RESET_WIDTH  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
   localparam int RESET_HEIGHT = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

   // Frame geometry, stored as the index of the last column and row.
   logic [CW-1:0] col_last_ff, col_last_in;
   logic [RW-1:0] row_last_ff, row_last_in;

   // Position of the next pixel to be accepted.
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // Read stage: the accepted pixel while the line buffer is read.
   logic          a_valid_ff, a_valid_in;
   pixel_type     a_pixel_ff;
   logic [CW-1:0] a_col_ff;
   logic [RW-1:0] a_row_ff;
   logic          a_interior_ff;
   logic          a_last_ff;

   // Window columns c-2 and c-1: [0..1] top, [2..3] middle, [4..5] bottom.
   pixel_type     win_ff [6];

   // Output register.
   logic          rsp_valid_ff, rsp_valid_in;
   pixel_type     rsp_edge_ff;
   logic [10:0]   rsp_row_ff;
   logic [10:0]   rsp_col_ff;
   logic          rsp_last_ff;

   logic          req_accept;
   logic          csr_write;
   logic          csr_hit;
   logic          out_free;
   logic          a_advance;
   logic          at_col_last;
   logic          at_row_last;
   line_pair_type lb_rd_data;
   line_pair_type lb_wr_data;
   pixel_type     edge_value;
   logic [CW-1:0] a_col_m1;
   logic [RW-1:0] a_row_m1;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign csr_hit    = (csr_index == REG_IMAGE_WIDTH) || (csr_index == REG_IMAGE_HEIGHT);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign a_advance  = a_valid_ff && out_free;
   assign req_tready = !a_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;

   assign at_col_last = (col_ff == col_last_ff);
   assign at_row_last = (row_ff == row_last_ff);

   // Register values below 3 act as 3, values above the maximum as the maximum.
   always_comb begin
      col_last_in = col_last_ff;
      row_last_in = row_last_ff;
      if (csr_write && csr_index == REG_IMAGE_WIDTH) begin
         if (csr_data < 12'd3) begin
            col_last_in = CW'(2);
         end else if (32'(csr_data) > 32'(MAX_WIDTH)) begin
            col_last_in = CW'(MAX_WIDTH - 1);
         end else begin
            col_last_in = CW'(csr_data - 12'd1);
         end
      end
      if (csr_write && csr_index == REG_IMAGE_HEIGHT) begin
         if (csr_data < 12'd3) begin
            row_last_in = RW'(2);
         end else if (32'(csr_data) > 32'(MAX_HEIGHT)) begin
            row_last_in = RW'(MAX_HEIGHT - 1);
         end else begin
            row_last_in = RW'(csr_data - 12'd1);
         end
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write && csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         if (at_col_last) begin
            col_in = '0;
            row_in = at_row_last ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_last_ff <= CW'(RESET_WIDTH - 1);
         row_last_ff <= RW'(RESET_HEIGHT - 1);
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         col_last_ff <= col_last_in;
         row_last_ff <= row_last_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
      end
   end

   // Read stage.
   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_accept) begin
         a_valid_in = 1'b1;
      end else if (a_advance) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_pixel_ff    <= req_tdata;
         a_col_ff      <= col_ff;
         a_row_ff      <= row_ff;
         a_interior_ff <= (col_ff >= CW'(2)) && (row_ff >= RW'(2));
         a_last_ff     <= at_col_last && at_row_last;
      end
   end

   // The entry for this column moves down one line as the pixel leaves the read
   // stage. The same column is read again only a full row later, after this write.
   assign lb_wr_data.upper  = lb_rd_data.middle;
   assign lb_wr_data.middle = a_pixel_ff;

   sobel_line_buf #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_buf (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (lb_rd_data),
      .wr_en   (a_advance),
      .wr_addr (a_col_ff),
      .wr_data (lb_wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (a_advance) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= lb_rd_data.upper;
         win_ff[2] <= win_ff[3];
         win_ff[3] <= lb_rd_data.middle;
         win_ff[4] <= win_ff[5];
         win_ff[5] <= a_pixel_ff;
      end
   end

   assign edge_value = sobel_magnitude(
      win_ff[0], win_ff[1], lb_rd_data.upper,
      win_ff[2], lb_rd_data.middle,
      win_ff[4], win_ff[5], a_pixel_ff
   );

   assign a_col_m1 = a_col_ff - CW'(1);
   assign a_row_m1 = a_row_ff - RW'(1);

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = a_valid_ff && a_interior_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_advance && a_interior_ff) begin
         rsp_edge_ff <= edge_value;
         rsp_row_ff  <= 11'(a_row_m1);
         rsp_col_ff  <= 11'(a_col_m1);
         rsp_last_ff <= a_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_col_ff, rsp_row_ff, rsp_edge_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // The column position never runs past the configured last column.
   assert property (@(posedge clock) disable iff (reset) col_ff <= col_last_ff)
      else $error("column position beyond last column");

   // Only interior pixels produce results.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_row_ff != 11'd0) && (rsp_col_ff != 11'd0))
      else $error("result for a border pixel");

   // A pixel is never taken while the read stage is full and cannot drain.
   assert property (@(posedge clock) disable iff (reset)
      !(req_accept && a_valid_ff && !out_free))
      else $error("read stage overwritten");

   // A stalled result is not replaced.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff && $stable(rsp_edge_ff))
      else $error("stalled result lost");
`endif

endmodule

// ===== src/sobel_line_buf.sv =====
module sobel_line_buf #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic                    clock,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output sobel_pkg::line_pair_type rd_data,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  sobel_pkg::line_pair_type wr_data
);
   import sobel_pkg::*;

   line_pair_type mem [DEPTH];
   line_pair_type rd_data_ff;

   // The read register only loads on a read, so it holds while the consumer stalls.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/sv/sobel_edge_checker.sv =====
`timescale 1ns / 100ps

// Watches the pixel, result and register channels of the Sobel block. It keeps
// its own copy of the frame geometry, line buffers and window. It predicts the
// edge result of every accepted pixel that completes an interior window and
// compares each result transaction with the oldest prediction.
module sobel_edge_checker #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [7:0]               req_tdata,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [31:0]              rsp_tdata,
   input  logic                     rsp_tlast,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  sobel_pkg::csr_index_type csr_index,
   input  sobel_pkg::csr_data_type  csr_data,
   output int                       error_count,
   output int                       pending_results
);
   import sobel_pkg::*;

   localparam int REPORT_LIMIT = 40;

   typedef struct packed {
      pixel_type   magnitude;
      logic [10:0] center_row;
      logic [10:0] center_col;
      logic        frame_end;
   } gradient_result_type;

   csr_data_type        width_setting;
   csr_data_type        height_setting;
   pixel_type           upper_line [MAX_WIDTH];
   pixel_type           middle_line [MAX_WIDTH];
   pixel_type           window [6];
   int                  col_pos;
   int                  row_pos;
   int                  mismatches;
   gradient_result_type expected_edges [$];

   initial begin
      mismatches = 0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
   end

   function automatic int frame_extent(input csr_data_type setting, input int limit);
      if (setting < 3) begin
         return 3;
      end
      if (setting > limit) begin
         return limit;
      end
      return int'(setting);
   endfunction

   task automatic predict_pixel(input pixel_type incoming);
      int                  span_w;
      int                  span_h;
      int                  top;
      int                  mid;
      int                  bot;
      int                  t0;
      int                  t1;
      int                  m0;
      int                  b0;
      int                  b1;
      int                  gx;
      int                  gy;
      int                  total;
      gradient_result_type outcome;
      span_w = frame_extent(width_setting, MAX_WIDTH);
      span_h = frame_extent(height_setting, MAX_HEIGHT);
      top = upper_line[col_pos];
      mid = middle_line[col_pos];
      bot = incoming;
      t0  = window[0];
      t1  = window[1];
      m0  = window[2];
      b0  = window[4];
      b1  = window[5];
      if (row_pos >= 2 && col_pos >= 2) begin
         // The incoming pixel is the bottom right corner of the window.
         gx = (top + 2 * mid + bot) - (t0 + 2 * m0 + b0);
         gy = (t0 + 2 * t1 + top) - (b0 + 2 * b1 + bot);
         if (gx < 0) begin
            gx = -gx;
         end
         if (gy < 0) begin
            gy = -gy;
         end
         total = gx + gy;
         if (total > int'(EDGE_MAX)) begin
            total = int'(EDGE_MAX);
         end
         outcome.magnitude  = pixel_type'(total);
         outcome.center_row = 11'(row_pos - 1);
         outcome.center_col = 11'(col_pos - 1);
         outcome.frame_end  = (row_pos + 1 >= span_h) && (col_pos + 1 >= span_w);
         expected_edges.push_back(outcome);
      end
      upper_line[col_pos]  = pixel_type'(mid);
      middle_line[col_pos] = incoming;
      window[0] = window[1];
      window[1] = pixel_type'(top);
      window[2] = window[3];
      window[3] = pixel_type'(mid);
      window[4] = window[5];
      window[5] = incoming;
      if (col_pos + 1 >= span_w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= span_h) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endtask

   task automatic check_result();
      gradient_result_type actual;
      gradient_result_type predicted;
      actual.magnitude  = rsp_tdata[7:0];
      actual.center_row = rsp_tdata[18:8];
      actual.center_col = rsp_tdata[29:19];
      actual.frame_end  = rsp_tlast;
      if (expected_edges.size() == 0) begin
         if (mismatches < REPORT_LIMIT) begin
            $display("%0t: unexpected edge result: expected none, actual value %0d row %0d",
                     $time, actual.magnitude, actual.center_row,
                     " col %0d last %0d", actual.center_col, actual.frame_end);
         end
         mismatches++;
      end else begin
         predicted = expected_edges.pop_front();
         if (actual !== predicted) begin
            if (mismatches < REPORT_LIMIT) begin
               $display("%0t: edge result mismatch: expected value %0d row %0d col %0d last %0d,",
                        $time, predicted.magnitude, predicted.center_row,
                        predicted.center_col, predicted.frame_end,
                        " actual value %0d row %0d col %0d last %0d",
                        actual.magnitude, actual.center_row, actual.center_col,
                        actual.frame_end);
            end
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_setting  = 12'd640;
         height_setting = 12'd480;
         col_pos = 0;
         row_pos = 0;
         for (int i = 0; i < 6; i++) begin
            window[i] = '0;
         end
         expected_edges.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            // Only known registers restart the frame position.
            if (csr_index == REG_IMAGE_WIDTH) begin
               width_setting = csr_data;
               col_pos = 0;
               row_pos = 0;
            end else if (csr_index == REG_IMAGE_HEIGHT) begin
               height_setting = csr_data;
               col_pos = 0;
               row_pos = 0;
            end
         end
         if (req_tvalid && req_tready) begin
            predict_pixel(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            check_result();
         end
      end
      error_count     <= mismatches;
      pending_results <= expected_edges.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import sobel_pkg::*;

   localparam real CLOCK_PERIOD  = 12.0;
   localparam int  IDLE_LIMIT    = 2000;
   localparam int  DRAIN_CYCLES  = 8;
   localparam int  RANDOM_PIXELS = 1100;

   localparam csr_index_type UNUSED_INDEX = 8'hFF;

   typedef enum int {
      TEXTURE_NOISE,
      TEXTURE_BINARY,
      TEXTURE_SMOOTH
   } texture_type;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata  = 8'h00;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [31:0]   rsp_tdata;
   logic          rsp_tlast;
   logic          csr_valid  = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index  = '0;
   csr_data_type  csr_data   = '0;
   int            error_count;
   int            pending_results;
   int            idle_cycles = 0;
   int            ready_run   = 0;
   pixel_type     pixel_stream [$];

   always #(CLOCK_PERIOD / 2.0) clock = ~clock;

   sobel_edge_magnitude u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   sobel_edge_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .error_count     (error_count),
      .pending_results (pending_results)
   );

   // The receiver alternates between open stretches and short stalls. Now and
   // then an open stretch runs long so that the pipeline sees full rate.
   always @(posedge clock) begin
      if (ready_run != 0) begin
         ready_run <= ready_run - 1;
      end else begin
         rsp_tready <= !rsp_tready;
         if (rsp_tready) begin
            ready_run <= $urandom_range(0, 20);
         end else if ($urandom_range(0, 7) == 0) begin
            ready_run <= $urandom_range(100, 300);
         end else begin
            ready_run <= $urandom_range(0, 15);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Leaves csr_valid high so that back-to-back writes follow without a gap;
   // the caller lowers it after the last write.
   task automatic write_register(input csr_index_type index, input csr_data_type setting);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= setting;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_frame_size(input csr_data_type cols, input csr_data_type rows);
      write_register(REG_IMAGE_WIDTH, cols);
      write_register(REG_IMAGE_HEIGHT, rows);
      csr_valid <= 1'b0;
   endtask

   task automatic fill_random(input int count, input texture_type texture);
      pixel_type base;
      base = pixel_type'($urandom);
      repeat (count) begin
         case (texture)
            TEXTURE_NOISE: begin
               pixel_stream.push_back(pixel_type'($urandom));
            end
            TEXTURE_BINARY: begin
               pixel_stream.push_back(($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00);
            end
            default: begin
               pixel_stream.push_back(base + pixel_type'($urandom_range(0, 3)));
            end
         endcase
      end
   endtask

   // Sends the queued pixels in bursts of random length with random gaps.
   task automatic send_stream();
      int burst;
      int gap;
      while (pixel_stream.size() != 0) begin
         burst = $urandom_range(1, 24);
         while (burst != 0 && pixel_stream.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pixel_stream.pop_front();
            do @(posedge clock); while (!req_tready);
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   // Border pixels may still be in the pipeline after the last result, so the
   // wait goes on past it.
   task automatic wait_idle();
      do @(posedge clock); while (pending_results != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int          random_count;
      int          kind;
      int          count;
      int          new_w;
      int          new_h;
      texture_type texture;

      random_count = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry of 640 columns: the first row gives no results.
      fill_random(40, TEXTURE_NOISE);
      send_stream();
      wait_idle();

      // Sizes below the minimum act as 3 x 3. The first frame has a hard
      // vertical edge that saturates; the second wraps into a new frame.
      set_frame_size(12'd0, 12'd2);
      for (int i = 0; i < 9; i++) begin
         pixel_stream.push_back((i % 3 == 2) ? 8'hFF : 8'h00);
      end
      for (int i = 0; i < 9; i++) begin
         pixel_stream.push_back(pixel_type'(i + 1));
      end
      for (int i = 0; i < 4; i++) begin
         pixel_stream.push_back(8'h00);
      end
      send_stream();
      wait_idle();

      // Writes to unknown registers must leave the frame position alone.
      write_register(UNUSED_INDEX, 12'hFFF);
      write_register(csr_index_type'(REG_IMAGE_HEIGHT + 1), 12'h000);
      csr_valid <= 1'b0;
      for (int i = 0; i < 5; i++) begin
         pixel_stream.push_back(8'h00);
      end
      send_stream();
      wait_idle();

      // Settings beyond the maximum act as the maximum. A row of the widest
      // frame is longer than this stream, so no result is expected.
      set_frame_size(12'hFFF, 12'd1);
      fill_random(40, TEXTURE_NOISE);
      send_stream();
      wait_idle();
      set_frame_size(12'd1, 12'd2049);
      fill_random(3 * 5, TEXTURE_BINARY);
      send_stream();
      wait_idle();

      while (random_count < RANDOM_PIXELS) begin
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            new_w = $urandom_range(0, 10);
            new_h = $urandom_range(0, 8);
         end else if (kind == 7) begin
            new_w = $urandom_range(0, 4095);
            new_h = $urandom_range(0, 6);
         end else begin
            new_w = $urandom_range(0, 6);
            new_h = $urandom_range(0, 4095);
         end
         if ($urandom_range(0, 5) != 0) begin
            write_register(REG_IMAGE_WIDTH, csr_data_type'(new_w));
         end
         if ($urandom_range(0, 5) != 0) begin
            write_register(REG_IMAGE_HEIGHT, csr_data_type'(new_h));
         end
         if ($urandom_range(0, 4) == 0) begin
            write_register(csr_index_type'($urandom_range(2, 255)),
                           csr_data_type'($urandom));
         end
         csr_valid <= 1'b0;
         if (kind < 7) begin
            // Whole frames followed by a partial one that the next write cuts.
            count = $urandom_range(0, 2) * ((new_w < 3) ? 3 : new_w) *
                    ((new_h < 3) ? 3 : new_h) + $urandom_range(1, 30);
         end else begin
            count = $urandom_range(1, 150);
         end
         texture = texture_type'($urandom_range(0, 2));
         fill_random(count, texture);
         send_stream();
         wait_idle();
         random_count += count;
      end

      if (error_count == 0 && pending_results == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/sobel_pkg.sv
src/sobel_line_buf.sv
src/sobel_edge_magnitude.sv
tb/sv/sobel_edge_checker.sv
tb/sv/tb.sv
